>>> src/pkt_pkg.sv
// Package for the pressed key tracker: sequencer states, request codes,
// fixed field widths and the compare unit result type. No dependencies.
package pkt_pkg;

	localparam int CODE_W = 31;
	localparam int REQ_W  = 2;

	localparam logic [REQ_W-1:0] REQ_PRESS   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN1,
		ST_FIN1,
		ST_UPDATE,
		ST_SCAN2,
		ST_FIN2,
		ST_DONE
	} pkt_state_t;

	typedef struct packed {
		logic hit;     // valid slot holds the key
		logic better;  // valid slot beats the best stamp so far
	} pkt_cmp_res_t;

endpackage

>>> src/pressed_key_tracker.sv
// Pressed key tracker top level: sequencer, slot valid bits, press counter
// and result register. Depends on pkt_pkg, pkt_slot_mem and pkt_cmp.
//
//  channel | direction | signals                                    | transfer
//  --------+-----------+--------------------------------------------+-------------------
//  in      | to block  | req_type, key_code                         | in_valid & in_ready
//  out     | from block| key_held, any_held, latest_key, dropped    | out_valid & out_ready
//
// Each item makes two passes over the slot memory, one read a cycle through its
// single read port, plus update and wrap-up; a new item is taken only in idle.
// Reset clears the valid bits, press counter and sequencer; memory contents
// are only read through a valid bit, so they need no clearing.
// A result waiting on out_ready does not stop the next transfer in; a
// second result waits in the wrap-up state until the output register frees.
module pressed_key_tracker
	import pkt_pkg::*;
#(
	parameter int SLOTS      = 128,
	parameter int STAMP_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [CODE_W-1:0]   key_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                key_held,
	output logic                any_held,
	output logic [CODE_W-1:0]   latest_key,
	output logic                dropped
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	pkt_state_t state_q, state_d;

	logic [REQ_W-1:0]       req_q;
	logic [CODE_W-1:0]      key_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       idx_s1;
	logic                   cmp_en_s1;
	logic [SLOTS-1:0]       valid_q;
	logic [STAMP_BITS-1:0]  press_ctr_q;

	logic                   found_q, free_found_q;
	logic [IDX_W-1:0]       found_idx_q, free_idx_q;
	logic                   dropped_q, held_q, any_q, have_q;
	logic [STAMP_BITS-1:0]  best_q;
	logic [CODE_W-1:0]      latest_q;

	logic                   out_valid_q;
	logic                   key_held_q, any_held_q, dropped_out_q;
	logic [CODE_W-1:0]      latest_key_q;

	logic                   load_out;
	logic                   scan_issue;
	logic                   phase2;
	logic                   is_press, is_release;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;

	logic [CODE_W-1:0]      rd_code;
	logic [STAMP_BITS-1:0]  rd_stamp;
	logic                   ent_valid;
	pkt_cmp_res_t           cmp_res;

	pkt_slot_mem #(
		.DEPTH   (SLOTS),
		.STAMP_W (STAMP_BITS)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wcode  (key_q),
		.wstamp (press_ctr_q),
		.raddr  (idx_q),
		.rcode  (rd_code),
		.rstamp (rd_stamp)
	);

	assign ent_valid = valid_q[idx_s1];

	pkt_cmp #(
		.STAMP_W (STAMP_BITS)
	) u_cmp (
		.ent_valid  (ent_valid),
		.ent_code   (rd_code),
		.ent_stamp  (rd_stamp),
		.key        (key_q),
		.best_stamp (best_q),
		.have_best  (have_q),
		.res        (cmp_res)
	);

	// Code 0 never takes part in a press or a release
	assign is_press   = (req_q == REQ_PRESS) && (key_q != '0);
	assign is_release = (req_q == REQ_RELEASE) && (key_q != '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = found_idx_q;
		if (state_q == ST_UPDATE && is_press) begin
			if (found_q) begin
				mem_we = 1'b1;
			end else if (free_found_q) begin
				mem_we    = 1'b1;
				mem_waddr = free_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		load_out   = 1'b0;
		scan_issue = 1'b0;
		phase2     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN1;
				end
			end
			ST_SCAN1: begin
				scan_issue = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_FIN1;
				end
			end
			ST_FIN1: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_SCAN2;
			end
			ST_SCAN2: begin
				scan_issue = 1'b1;
				phase2     = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_FIN2;
				end
			end
			ST_FIN2: begin
				phase2  = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// scan address and compare pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= scan_issue;
			if (scan_issue) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			press_ctr_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
				press_ctr_q        <= press_ctr_q + 1'b1;
			end else if (is_release && found_q) begin
				valid_q[found_idx_q] <= 1'b0;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			dropped_q    <= 1'b0;
			held_q       <= 1'b0;
			any_q        <= 1'b0;
			have_q       <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				dropped_q    <= 1'b0;
			end else if (state_q == ST_UPDATE) begin
				held_q <= 1'b0;
				any_q  <= 1'b0;
				have_q <= 1'b0;
				if (is_press && !found_q && !free_found_q) begin
					dropped_q <= 1'b1;
				end
			end else if (cmp_en_s1 && !phase2) begin
				if (cmp_res.hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (!ent_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end else if (cmp_en_s1 && phase2) begin
				if (cmp_res.hit) begin
					held_q <= 1'b1;
				end
				if (ent_valid) begin
					any_q <= 1'b1;
				end
				if (cmp_res.better) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_type;
			key_q <= key_code;
		end
		if (state_q == ST_UPDATE) begin
			latest_q <= '0;
		end
		if (cmp_en_s1 && !phase2) begin
			if (cmp_res.hit && !found_q) begin
				found_idx_q <= idx_s1;
			end
			if (!ent_valid && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (cmp_en_s1 && phase2 && cmp_res.better) begin
			best_q   <= rd_stamp;
			latest_q <= rd_code;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			key_held_q    <= held_q;
			any_held_q    <= any_q;
			latest_key_q  <= latest_q;
			dropped_out_q <= dropped_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_held   = key_held_q;
	assign any_held   = any_held_q;
	assign latest_key = latest_key_q;
	assign dropped    = dropped_out_q;

`ifndef SYNTHESIS
	// a held slot never carries code 0, so a non-zero latest key means something is held
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (any_held || (latest_key == '0)))
		else $error("latest_key set while nothing held");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_held) |-> any_held)
		else $error("key_held without any slot held");

	// a drop only happens with every slot taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped) |-> any_held)
		else $error("press dropped with a free slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(press_ctr_q != $past(press_ctr_q)) |-> ($past(state_q) == ST_UPDATE))
		else $error("press counter moved outside the update step");
`endif

endmodule

>>> src/pkt_slot_mem.sv
// Slot table storage: key code and press stamp per slot, one write port,
// one registered read port. Depends on pkt_pkg.
module pkt_slot_mem
	import pkt_pkg::*;
#(
	parameter int DEPTH   = 128,
	parameter int STAMP_W = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [CODE_W-1:0]          wcode,
	input  logic [STAMP_W-1:0]         wstamp,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [CODE_W-1:0]          rcode,
	output logic [STAMP_W-1:0]         rstamp
);

	logic [CODE_W+STAMP_W-1:0] mem [DEPTH];
	logic [CODE_W+STAMP_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wcode, wstamp};
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rcode  = rdata_q[CODE_W+STAMP_W-1:STAMP_W];
	assign rstamp = rdata_q[STAMP_W-1:0];

endmodule

>>> src/pkt_cmp.sv
// Shared compare unit: code match and stamp magnitude compare for one slot.
// Used by both table scans. Depends on pkt_pkg.
module pkt_cmp
	import pkt_pkg::*;
#(
	parameter int STAMP_W = 32
) (
	input  logic                ent_valid,
	input  logic [CODE_W-1:0]   ent_code,
	input  logic [STAMP_W-1:0]  ent_stamp,
	input  logic [CODE_W-1:0]   key,
	input  logic [STAMP_W-1:0]  best_stamp,
	input  logic                have_best,
	output pkt_cmp_res_t        res
);

	always_comb begin
		res.hit    = ent_valid && (ent_code == key);
		res.better = ent_valid && (!have_best || (ent_stamp > best_stamp));
	end

endmodule

>>> dv/pkt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pressed key tracker: watches both channels, keeps its own slot table
// and compares every result transfer with the oldest outstanding prediction. Needs pkt_pkg.
module pkt_checker
	import pkt_pkg::*;
#(
	parameter int SLOTS      = 128,
	parameter int STAMP_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [CODE_W-1:0] key_code,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              key_held,
	input  logic              any_held,
	input  logic [CODE_W-1:0] latest_key,
	input  logic              dropped,
	output int unsigned       fail_count,
	output int unsigned       pending_results
);

	typedef struct packed {
		logic              key_held;
		logic              any_held;
		logic [CODE_W-1:0] latest_key;
		logic              dropped;
	} key_report_t;

	logic                  held_valid [SLOTS];
	logic [CODE_W-1:0]     held_code  [SLOTS];
	logic [STAMP_BITS-1:0] held_stamp [SLOTS];
	logic [STAMP_BITS-1:0] next_stamp;
	key_report_t           expected_reports [$];

	function automatic int find_held_slot(input logic [CODE_W-1:0] code);
		int slot;
		slot = -1;
		if (code != '0) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot < 0 && held_valid[i] && held_code[i] == code)
					slot = i;
			end
		end
		return slot;
	endfunction

	// Applies one key event to the local table and returns the report the block should give.
	function automatic key_report_t track_key_event(input logic [REQ_W-1:0] req,
			input logic [CODE_W-1:0] code);
		key_report_t           rep;
		int                    slot;
		logic                  found;
		logic [STAMP_BITS-1:0] best;
		rep   = '0;
		slot  = find_held_slot(code);
		found = 1'b0;
		best  = '0;
		if (code != '0) begin
			case (req)
				REQ_PRESS: begin
					// not held already: lowest free slot
					if (slot < 0) begin
						for (int i = SLOTS - 1; i >= 0; i--) begin
							if (!held_valid[i])
								slot = i;
						end
					end
					if (slot < 0) begin
						rep.dropped = 1'b1;
					end else begin
						held_valid[slot] = 1'b1;
						held_code[slot]  = code;
						held_stamp[slot] = next_stamp;
						next_stamp       = next_stamp + 1'b1;
					end
				end
				REQ_RELEASE: begin
					if (slot >= 0) begin
						held_valid[slot] = 1'b0;
						held_code[slot]  = '0;
						held_stamp[slot] = '0;
					end
				end
				default: ;
			endcase
		end
		// strict compare: on equal stamps the lower slot keeps the lead
		for (int i = 0; i < SLOTS; i++) begin
			if (held_valid[i]) begin
				rep.any_held = 1'b1;
				if (!found || held_stamp[i] > best) begin
					found          = 1'b1;
					best           = held_stamp[i];
					rep.latest_key = held_code[i];
				end
			end
		end
		rep.key_held = (find_held_slot(code) >= 0);
		return rep;
	endfunction

	task automatic compare_field(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				held_valid[i] = 1'b0;
				held_code[i]  = '0;
				held_stamp[i] = '0;
			end
			next_stamp = '0;
			expected_reports.delete();
		end else begin
			// result side first, so a stray result is never matched to this edge's input
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("result transfer with no item outstanding");
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					compare_field("key_held", CODE_W'(want.key_held), CODE_W'(key_held));
					compare_field("any_held", CODE_W'(want.any_held), CODE_W'(any_held));
					compare_field("latest_key", want.latest_key, latest_key);
					compare_field("dropped", CODE_W'(want.dropped), CODE_W'(dropped));
				end
			end
			if (in_valid && in_ready)
				expected_reports.push_back(track_key_event(req_type, key_code));
		end
		pending_results = expected_reports.size();
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Top level testbench for pressed_key_tracker: clock, reset, key event stimulus and the
// verdict. Needs pkt_pkg, the tracker RTL and pkt_checker.
module tb_top
	import pkt_pkg::*;
();

	localparam int SLOTS          = 128;
	localparam int STAMP_BITS     = 32;
	localparam int POOL_SIZE      = 160;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 300;
	localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
	localparam logic [CODE_W-1:0] CODE_NONE  = '0;
	localparam logic [CODE_W-1:0] CODE_MAX   = 31'h7FFF_FFFF;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [REQ_W-1:0]  req_type;
	logic [CODE_W-1:0] key_code;
	logic              out_valid;
	logic              out_ready;
	logic              key_held;
	logic              any_held;
	logic [CODE_W-1:0] latest_key;
	logic              dropped;
	int unsigned       fail_count;
	int unsigned       pending_results;
	int unsigned       idle_cycles = 0;
	logic              quiet = 1'b0;
	logic [CODE_W-1:0] key_pool [POOL_SIZE];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	pressed_key_tracker #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key_code   (key_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_held   (key_held),
		.any_held   (any_held),
		.latest_key (latest_key),
		.dropped    (dropped)
	);

	pkt_checker #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.key_code        (key_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.key_held        (key_held),
		.any_held        (any_held),
		.latest_key      (latest_key),
		.dropped         (dropped),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// any cycle without a transfer on either side counts towards the limit
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver back-pressure in bursts, none once the run goes quiet
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer (and any gap).
	task automatic send_item(input logic [REQ_W-1:0] req, input logic [CODE_W-1:0] code);
		int gap;
		in_valid <= 1'b1;
		req_type <= req;
		key_code <= code;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (roll < 92)
			return CODE_W'($urandom);
		return CODE_NONE;
	endfunction

	task automatic run_key_mix(input int n_items, input int press_pct, input int release_pct);
		int               roll;
		logic [REQ_W-1:0] req;
		repeat (n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < press_pct)
				req = REQ_PRESS;
			else if (roll < press_pct + release_pct)
				req = REQ_RELEASE;
			else if (roll < 95)
				req = REQ_QUERY;
			else
				req = REQ_UNUSED;
			send_item(req, pick_code());
		end
	endtask

	initial begin
		int                j;
		logic [CODE_W-1:0] swap;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_QUERY;
		key_code = CODE_NONE;

		key_pool[0] = 31'd1;
		key_pool[1] = CODE_MAX;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = CODE_W'($urandom_range(1, 32'h7FFF_FFFF));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, code zero, extremes, repeats, unused request type
		send_item(REQ_QUERY, CODE_NONE);
		send_item(REQ_PRESS, CODE_NONE);
		send_item(REQ_RELEASE, CODE_NONE);
		send_item(REQ_RELEASE, 31'd5);
		send_item(REQ_PRESS, CODE_MAX);
		send_item(REQ_PRESS, 31'd1);
		send_item(REQ_QUERY, CODE_MAX);
		send_item(REQ_PRESS, CODE_MAX);
		send_item(REQ_UNUSED, 31'd1);
		send_item(REQ_UNUSED, CODE_NONE);
		send_item(REQ_PRESS, 31'h5555_5555);
		send_item(REQ_PRESS, 31'h2AAA_AAAA);
		send_item(REQ_RELEASE, 31'h2AAA_AAAA);
		send_item(REQ_PRESS, 31'h2AAA_AAAA);
		send_item(REQ_QUERY, CODE_NONE);
		send_item(REQ_RELEASE, CODE_MAX);
		send_item(REQ_RELEASE, CODE_MAX);
		send_item(REQ_RELEASE, 31'd1);
		send_item(REQ_RELEASE, 31'h5555_5555);
		send_item(REQ_RELEASE, 31'h2AAA_AAAA);
		send_item(REQ_QUERY, 31'd1);

		// fill: press the whole pool in random order, the table overflows near the end
		for (int i = POOL_SIZE - 1; i > 0; i--) begin
			j           = $urandom_range(0, i);
			swap        = key_pool[i];
			key_pool[i] = key_pool[j];
			key_pool[j] = swap;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			send_item(REQ_PRESS, key_pool[i]);

		run_key_mix(250, 45, 35);
		run_key_mix(200, 15, 70);
		quiet = 1'b1;
		run_key_mix(120, 40, 40);

		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
